// ===== rtl/c128b_pkg.sv =====
// ---------------------------------------------------------------------------
// c128b_pkg : shared types and constants for the Code 128 set B framer
// Result kinds, font character constants, the beat descriptor passed from
// the sequencer, and a modulo-103 reduction built from constant folds.
// ---------------------------------------------------------------------------
package c128b_pkg;

   localparam int unsigned MODULUS     = 103;
   localparam int unsigned CHAR_OFFSET = 105;
   localparam int unsigned HIGH_REMAIN = 95;
   localparam int unsigned ASCII_BASE  = 32;
   localparam int unsigned SET_B_START = 104;
   localparam int unsigned STOP_CODE   = 106;

   localparam logic [7:0] START_CHAR = 8'(SET_B_START + CHAR_OFFSET);
   localparam logic [7:0] STOP_CHAR  = 8'(STOP_CODE + CHAR_OFFSET);
   localparam logic [6:0] SUM_INIT   = 7'(SET_B_START % MODULUS);
   localparam logic [6:0] WEIGHT_MAX = 7'(MODULUS - 1);

   // result kind, also the sequencer phase
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_CHECK = 2'd2,
      KIND_STOP  = 2'd3
   } kind_type;

   // one result beat leaving the sequencer
   typedef struct packed {
      logic       fire;       // beat is produced this cycle
      kind_type   kind;
      logic [7:0] data;       // held input byte
      logic       bad;        // data beat with byte outside 32..127
      logic       final_beat; // closes this input's run
   } emit_type;

   // x mod 103 for a 14-bit value; 128 == 25 (mod 103), so fold the high bits
   function automatic logic [6:0] mod103(input logic [13:0] x);
      logic [11:0] a;
      logic [9:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      a = 12'(x[13:7]) * 12'd25 + 12'(x[6:0]);
      b = 10'(a[11:7]) * 10'd25 + 10'(a[6:0]);
      c = 8'(b[9:7]) * 8'd25 + 8'(b[6:0]);
      d = 8'(c[7]) * 8'd25 + 8'(c[6:0]);
      if (d >= 8'(MODULUS)) begin
         d = d - 8'(MODULUS);
      end
      return d[6:0];
   endfunction

endpackage

// ===== rtl/code128b_frame_with_check.sv =====
// ---------------------------------------------------------------------------
// code128b_frame_with_check : Code 128 set B framer with check character
// Frames text bytes with start, check and stop font characters.
//
//  channel | dir | beat contents
//  req_    | in  | tdata[7:0] data_byte, tlast last
//  rsp_    | out | tdata[7:0] out_char, tuser[1:0] out_kind, tuser[2] bad_input,
//          |     | tlast out_last
//
//  One result beat per cycle from the output register; a mid-frame byte gives
//  a data beat, a frame's first byte start and data, its last byte data, check
//  and stop, a one-byte code all four kinds. The byte after the current one is
//  taken in the cycle its last beat is produced. The check path is a 7x7
//  product register feeding a mod-103 fold. Synchronous reset clears the frame;
//  rsp_tready low holds the output beat and stalls the sequencer.
// ---------------------------------------------------------------------------
module code128b_frame_with_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [1:0] out_kind, [2] bad_input
   output logic       rsp_tlast
);
   import c128b_pkg::*;

   emit_type   emit;
   logic       emit_ok;
   logic [7:0] check_char;
   logic [7:0] char_sel;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   kind_type   rsp_kind_ff;
   logic       rsp_bad_ff;
   logic       rsp_last_ff;

   assign emit_ok = ~rsp_valid_ff | rsp_tready;

   c128b_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .emit_ok    (emit_ok),
      .emit       (emit)
   );

   c128b_csum u_csum (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .check_char (check_char)
   );

   always_comb begin
      case (emit.kind)
         KIND_START: char_sel = START_CHAR;
         KIND_DATA:  char_sel = emit.data;
         KIND_CHECK: char_sel = check_char;
         KIND_STOP:  char_sel = STOP_CHAR;
         default:    char_sel = emit.data;
      endcase
   end

   assign rsp_valid_in = emit.fire | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.fire) begin
         rsp_char_ff <= char_sel;
         rsp_kind_ff <= emit.kind;
         rsp_bad_ff  <= emit.bad;
         rsp_last_ff <= emit.final_beat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/c128b_seq.sv =====
// ---------------------------------------------------------------------------
// c128b_seq : input register and result sequencer
// Holds one input byte and steps through start, data, check and stop
// beats as the output register frees up.
// ---------------------------------------------------------------------------
module c128b_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,
   input  logic              emit_ok,
   output c128b_pkg::emit_type emit
);
   import c128b_pkg::*;

   logic       item_valid_ff, item_valid_in;
   logic       frame_open_ff, frame_open_in;
   kind_type   phase_ff, phase_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       fire, item_done, load, byte_bad;

   assign fire     = item_valid_ff & emit_ok;
   assign byte_bad = byte_ff[7] | (byte_ff[7:5] == 3'd0);

   // output side of the sequencer
   always_comb begin
      item_done = 1'b0;
      unique case (phase_ff)
         KIND_START: item_done = 1'b0;
         KIND_DATA:  item_done = fire & ~last_ff;
         KIND_CHECK: item_done = 1'b0;
         KIND_STOP:  item_done = fire;
         default:    item_done = 1'b0;
      endcase
   end

   assign req_tready = ~item_valid_ff | item_done;
   assign load       = req_tvalid & req_tready;

   always_comb begin
      emit.fire       = fire;
      emit.kind       = phase_ff;
      emit.data       = byte_ff;
      emit.bad        = byte_bad & (phase_ff == KIND_DATA);
      emit.final_beat = (phase_ff == KIND_STOP) | ((phase_ff == KIND_DATA) & ~last_ff);
   end

   always_comb begin
      frame_open_in = frame_open_ff;
      if (fire && phase_ff == KIND_START) begin
         frame_open_in = 1'b1;
      end else if (fire && phase_ff == KIND_STOP) begin
         frame_open_in = 1'b0;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (load) begin
         phase_in = frame_open_in ? KIND_DATA : KIND_START;
      end else if (fire) begin
         unique case (phase_ff)
            KIND_START: phase_in = KIND_DATA;
            KIND_DATA:  phase_in = last_ff ? KIND_CHECK : KIND_DATA;
            KIND_CHECK: phase_in = KIND_STOP;
            KIND_STOP:  phase_in = KIND_STOP;
            default:    phase_in = KIND_START;
         endcase
      end
   end

   assign item_valid_in = load | (item_valid_ff & ~item_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         frame_open_ff <= 1'b0;
         phase_ff      <= KIND_START;
      end else begin
         item_valid_ff <= item_valid_in;
         frame_open_ff <= frame_open_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

endmodule

// ===== rtl/c128b_csum.sv =====
// ---------------------------------------------------------------------------
// c128b_csum : weighted checksum
// Registers (byte-32)*weight on each summed data beat and folds it into
// the mod-103 running sum in the next cycle; forms the check character.
// ---------------------------------------------------------------------------
module c128b_csum (
   input  logic                clock,
   input  logic                reset,
   input  c128b_pkg::emit_type emit,
   output logic [7:0]          check_char
);
   import c128b_pkg::*;

   logic [6:0]  weight_ff, weight_in;
   logic [6:0]  sum_ff, sum_in;
   logic [13:0] prod_ff, prod_in;
   logic        pend_ff, pend_in;
   logic        take, close;
   logic [6:0]  ofs;
   logic [6:0]  sum_now;

   assign take  = emit.fire & (emit.kind == KIND_DATA) & ~emit.bad;
   assign close = emit.fire & (emit.kind == KIND_STOP);
   assign ofs   = emit.data[6:0] - 7'(ASCII_BASE);

   // sum including the product still in flight
   assign sum_now = mod103(14'(sum_ff) + (pend_ff ? prod_ff : 14'd0));

   assign prod_in = 14'(ofs) * 14'(weight_ff);
   assign pend_in = take;
   assign sum_in  = close ? SUM_INIT : sum_now;

   always_comb begin
      weight_in = weight_ff;
      if (close) begin
         weight_in = 7'd1;
      end else if (take) begin
         weight_in = (weight_ff == WEIGHT_MAX) ? 7'd0 : weight_ff + 7'd1;
      end
   end

   assign check_char = (sum_now >= 7'(HIGH_REMAIN)) ? 8'(sum_now) + 8'(CHAR_OFFSET)
                                                    : 8'(sum_now) + 8'(ASCII_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 7'd1;
         sum_ff    <= SUM_INIT;
         pend_ff   <= 1'b0;
      end else begin
         weight_ff <= weight_in;
         sum_ff    <= sum_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/c128b_chk.sv =====
// ---------------------------------------------------------------------------
// c128b_chk : port-level checks for the Code 128 set B framer
// Watches the result channel for framing characters and beat stability.
// ---------------------------------------------------------------------------
module c128b_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);
   import c128b_pkg::*;

   logic unused_in;
   assign unused_in = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tlast;

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // a stalled beat keeps its contents
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // start beat: fixed character, never ends a run, never flagged
   a_start_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_START |->
         rsp_tdata == START_CHAR && !rsp_tlast && !rsp_tuser[2])
      else $error("bad start beat");

   // stop beat: fixed character and always closes the run
   a_stop_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_STOP |->
         rsp_tdata == STOP_CHAR && rsp_tlast && !rsp_tuser[2])
      else $error("bad stop beat");

   // check beat lies in one of the two character bands
   a_check_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_CHECK |->
         !rsp_tlast && !rsp_tuser[2]
         && ((rsp_tdata >= 8'd32 && rsp_tdata <= 8'd126)
             || (rsp_tdata >= 8'd200 && rsp_tdata <= 8'd207)))
      else $error("check character out of range");

endmodule

bind code128b_frame_with_check c128b_chk u_c128b_chk (.*);
